// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SED_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SED_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sed_pkg.sv
package sed_pkg;

   localparam int SECTOR_WORDS_DEF = 128;
   localparam int WORD_W           = 32;
   localparam int PASS_W           = 4;
   localparam int ROT_W            = 5;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_PASSES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_PASSES  = 2'd2;

   localparam logic [PASS_W-1:0] A_PASSES_RST = 4'd5;
   localparam logic [PASS_W-1:0] B_PASSES_RST = 4'd3;

   localparam logic [ROT_W-1:0] ROT_A [4] = '{5'd9, 5'd0, 5'd13, 5'd0};
   localparam logic [ROT_W-1:0] ROT_B [4] = '{5'd0, 5'd10, 5'd0, 5'd25};

   typedef struct packed {
      logic [WORD_W-1:0] word_even;
      logic [WORD_W-1:0] word_odd;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_even;
      logic [WORD_W-1:0] out_odd;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_LOAD_ODD,
      ST_SETUP,
      ST_DIFF,
      ST_DRAIN,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   function automatic logic [ROT_W-1:0] rot_amount(input logic is_b, input logic [1:0] sel);
      logic [ROT_W-1:0] r;
      if (is_b) begin
         r = ROT_B[sel];
      end else begin
         r = ROT_A[sel];
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                input logic [ROT_W-1:0] r);
      logic [2*WORD_W-1:0] t;
      t = {v, v} << r;
      return t[2*WORD_W-1:WORD_W];
   endfunction

endpackage

// File: hw/rtl/sector_elephant_diffuser_unit.sv
// sector diffuser: collects a sector of SECTOR_WORDS 32-bit words, two per input beat
// (even index, then odd index), filling from index 0. the beat that completes the
// sector starts diffusion in place; the diffused sector then leaves as one beat per
// word pair in index order, last set on the final pair.
// loading writes each beat's two words in turn (one write port) before the next beat.
// diffusion runs one word update per cycle, (a_passes + b_passes) * SECTOR_WORDS updates
// in all, with one setup state per diffuser and one drain state. the update pipeline
// reads the word and its two taps in one cycle from two copies of the sector memory
// and writes back the next cycle; a step never reads the word its predecessor is writing.
// emission reads each word pair from memory, then presents it as a result beat.
// req_stall is high whenever the block is not loading, rsp_valid only while a result
// is shown. a stalled result holds until taken; no input is taken meanwhile.
// reset (synchronous) returns to loading at index 0 and restores direction 0,
// a_passes 5, b_passes 3. the sector memory is not cleared. csr writes are taken
// any time but must only happen while the block is idle.
module sector_elephant_diffuser_unit #(
   parameter int SECTOR_WORDS = sed_pkg::SECTOR_WORDS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sed_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sed_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [sed_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sed_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IW    = $clog2(SECTOR_WORDS);
   localparam int FW    = IW - 1;
   localparam int PAIRS = (SECTOR_WORDS + 1) / 2;
   localparam logic [IW:0]   N_EXT     = (IW+1)'(SECTOR_WORDS);
   localparam logic [IW-1:0] J_MAX     = IW'(SECTOR_WORDS - 1);
   localparam logic [FW-1:0] PAIR_LAST = FW'(PAIRS - 1);
   localparam logic [3:0]    N_MOD4    = 4'(SECTOR_WORDS % 4);

   localparam int WW = sed_pkg::WORD_W;
   localparam int PW = sed_pkg::PASS_W;
   localparam int RW = sed_pkg::ROT_W;

   sed_pkg::state_type state_ff, state_in;

   logic [FW-1:0]   fill_ff, fill_in;
   logic [WW-1:0]   odd_ff, odd_in;
   logic            stage_ff, stage_in;
   logic [IW-1:0]   j_ff, j_in;
   logic [PW-1:0]   pass_ff, pass_in;
   logic [1:0]      rot_ctr_ff, rot_ctr_in;

   logic            s1_vld_ff, s1_vld_in;
   logic [IW-1:0]   s1_j_ff, s1_j_in;
   logic [RW-1:0]   s1_rot_ff, s1_rot_in;
   logic            s1_add_ff, s1_add_in;

   logic            dir_ff, dir_in;
   logic [PW-1:0]   a_pass_ff, a_pass_in;
   logic [PW-1:0]   b_pass_ff, b_pass_in;

   logic [WW-1:0]   mem0_ff [SECTOR_WORDS];
   logic [WW-1:0]   mem1_ff [SECTOR_WORDS];
   logic [WW-1:0]   q0_ff, q1_ff, q2_ff;

   logic            wr_en;
   logic [IW-1:0]   wr_addr;
   logic [WW-1:0]   wr_data;
   logic            rd_en;
   logic [IW-1:0]   rd_addr0, rd_addr1, rd_addr2;

   logic            is_b;
   logic            last_step;
   logic            last_pair;
   logic            odd_ok;
   logic [IW:0]     j_ext, odd_ext;
   logic [IW:0]     plus2, plus5, minus2, minus5;
   logic [IW-1:0]   near_addr, far_addr;
   logic [IW-1:0]   even_addr, odd_addr;
   logic [PW-1:0]   pass_sel;
   logic [3:0]      rot_prod;
   logic [1:0]      rot_start;
   logic [WW-1:0]   mix;
   logic [WW-1:0]   upd;

   // configuration registers
   always_comb begin
      dir_in    = dir_ff;
      a_pass_in = a_pass_ff;
      b_pass_in = b_pass_ff;
      if (csr_we) begin
         case (csr_index)
            sed_pkg::CSR_DIRECTION: dir_in    = csr_wdata[0];
            sed_pkg::CSR_A_PASSES:  a_pass_in = csr_wdata[PW-1:0];
            sed_pkg::CSR_B_PASSES:  b_pass_in = csr_wdata[PW-1:0];
            default: ;
         endcase
      end
   end

   // tap addresses, wrapped into the sector
   always_comb begin
      j_ext  = {1'b0, j_ff};
      plus2  = j_ext + (IW+1)'(2);
      plus5  = j_ext + (IW+1)'(5);
      if (plus2 >= N_EXT) plus2 = plus2 - N_EXT;
      if (plus5 >= N_EXT) plus5 = plus5 - N_EXT;
      if (j_ext >= (IW+1)'(2)) begin
         minus2 = j_ext - (IW+1)'(2);
      end else begin
         minus2 = j_ext + N_EXT - (IW+1)'(2);
      end
      if (j_ext >= (IW+1)'(5)) begin
         minus5 = j_ext - (IW+1)'(5);
      end else begin
         minus5 = j_ext + N_EXT - (IW+1)'(5);
      end
   end

   assign is_b      = stage_ff ^ dir_ff;
   assign near_addr = is_b ? plus2[IW-1:0] : minus2[IW-1:0];
   assign far_addr  = is_b ? plus5[IW-1:0] : minus5[IW-1:0];
   assign last_step = (pass_ff == PW'(1)) && (dir_ff ? (j_ff == J_MAX) : (j_ff == '0));

   assign even_addr = {fill_ff, 1'b0};
   assign odd_ext   = {1'b0, fill_ff, 1'b1};
   assign odd_ok    = odd_ext < N_EXT;
   assign odd_addr  = odd_ok ? {fill_ff, 1'b1} : even_addr;
   assign last_pair = fill_ff == PAIR_LAST;

   // counter phase of the first descending step: (passes * N - 1) mod 4
   assign pass_sel  = is_b ? b_pass_ff : a_pass_ff;
   assign rot_prod  = pass_sel * N_MOD4;
   assign rot_start = rot_prod[1:0] - 2'd1;

   assign mix = q0_ff ^ sed_pkg::rotl32(q1_ff, s1_rot_ff);
   assign upd = s1_add_ff ? (q2_ff + mix) : (q2_ff - mix);

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      odd_in     = odd_ff;
      stage_in   = stage_ff;
      j_in       = j_ff;
      pass_in    = pass_ff;
      rot_ctr_in = rot_ctr_ff;
      s1_vld_in  = 1'b0;
      s1_j_in    = s1_j_ff;
      s1_rot_in  = s1_rot_ff;
      s1_add_in  = s1_add_ff;
      wr_en      = 1'b0;
      wr_addr    = even_addr;
      wr_data    = req_data.word_even;
      rd_en      = 1'b0;
      rd_addr0   = near_addr;
      rd_addr1   = far_addr;
      rd_addr2   = j_ff;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;

      case (state_ff)
         sed_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               wr_en    = 1'b1;
               odd_in   = req_data.word_odd;
               state_in = sed_pkg::ST_LOAD_ODD;
            end
         end
         sed_pkg::ST_LOAD_ODD: begin
            // odd word past the end of an odd-sized sector is dropped
            wr_en   = odd_ok;
            wr_addr = odd_addr;
            wr_data = odd_ff;
            if (last_pair) begin
               fill_in  = '0;
               stage_in = 1'b0;
               state_in = sed_pkg::ST_SETUP;
            end else begin
               fill_in  = fill_ff + FW'(1);
               state_in = sed_pkg::ST_LOAD;
            end
         end
         sed_pkg::ST_SETUP: begin
            if (pass_sel == '0) begin
               if (stage_ff) begin
                  state_in = sed_pkg::ST_DRAIN;
               end else begin
                  stage_in = 1'b1;
               end
            end else begin
               pass_in    = pass_sel;
               j_in       = dir_ff ? '0 : J_MAX;
               rot_ctr_in = dir_ff ? 2'd0 : rot_start;
               state_in   = sed_pkg::ST_DIFF;
            end
         end
         sed_pkg::ST_DIFF: begin
            rd_en     = 1'b1;
            s1_vld_in = 1'b1;
            s1_j_in   = j_ff;
            s1_rot_in = sed_pkg::rot_amount(is_b, rot_ctr_ff);
            s1_add_in = dir_ff;
            if (dir_ff) begin
               rot_ctr_in = rot_ctr_ff + 2'd1;
               if (j_ff == J_MAX) begin
                  j_in    = '0;
                  pass_in = pass_ff - PW'(1);
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end else begin
               rot_ctr_in = rot_ctr_ff - 2'd1;
               if (j_ff == '0) begin
                  j_in    = J_MAX;
                  pass_in = pass_ff - PW'(1);
               end else begin
                  j_in = j_ff - IW'(1);
               end
            end
            if (last_step) begin
               if (stage_ff) begin
                  state_in = sed_pkg::ST_DRAIN;
               end else begin
                  stage_in = 1'b1;
                  state_in = sed_pkg::ST_SETUP;
               end
            end
         end
         sed_pkg::ST_DRAIN: begin
            // lets the final write-back land before word 0 is read
            state_in = sed_pkg::ST_EMIT_RD;
         end
         sed_pkg::ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr0 = even_addr;
            rd_addr1 = odd_addr;
            state_in = sed_pkg::ST_EMIT_OUT;
         end
         sed_pkg::ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (last_pair) begin
                  fill_in  = '0;
                  state_in = sed_pkg::ST_LOAD;
               end else begin
                  fill_in  = fill_ff + FW'(1);
                  state_in = sed_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = sed_pkg::ST_LOAD;
         end
      endcase

      // write-back of the step issued last cycle
      if (s1_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = s1_j_ff;
         wr_data = upd;
      end
   end

   assign rsp_data.out_even = q0_ff;
   assign rsp_data.out_odd  = odd_ok ? q1_ff : '0;
   assign rsp_data.last     = last_pair;

   // two copies of the sector, written together, three read ports in all
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem0_ff[wr_addr] <= wr_data;
         mem1_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q0_ff <= mem0_ff[rd_addr0];
         q1_ff <= mem0_ff[rd_addr1];
         q2_ff <= mem1_ff[rd_addr2];
      end
   end

   always_ff @(posedge clock) begin
      odd_ff    <= odd_in;
      s1_j_ff   <= s1_j_in;
      s1_rot_ff <= s1_rot_in;
      s1_add_ff <= s1_add_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sed_pkg::ST_LOAD;
         fill_ff    <= '0;
         stage_ff   <= 1'b0;
         j_ff       <= '0;
         pass_ff    <= '0;
         rot_ctr_ff <= '0;
         s1_vld_ff  <= 1'b0;
         dir_ff     <= 1'b0;
         a_pass_ff  <= sed_pkg::A_PASSES_RST;
         b_pass_ff  <= sed_pkg::B_PASSES_RST;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         stage_ff   <= stage_in;
         j_ff       <= j_in;
         pass_ff    <= pass_in;
         rot_ctr_ff <= rot_ctr_in;
         s1_vld_ff  <= s1_vld_in;
         dir_ff     <= dir_in;
         a_pass_ff  <= a_pass_in;
         b_pass_ff  <= b_pass_in;
      end
   end

endmodule

// File: hw/rtl/sed_checker.sv
`include "assert_macros.svh"

module sed_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sed_pkg::rsp_type rsp_data
);

   // a result beat waiting on the receiver stays offered
   `SED_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   // the input side is open only while no result is offered
   `SED_ASSERT_IMP(a_no_overlap, clock, reset, !req_stall, !rsp_valid, "req open during rsp")

   // each input beat takes two memory writes, so the next cycle is closed
   `SED_ASSERT_NXT(a_load_gap, clock, reset, req_valid && !req_stall, req_stall, "req open after beat")

   // after the final pair leaves, no result follows right away
   `SED_ASSERT_NXT(a_last_end, clock, reset, rsp_valid && !rsp_stall && rsp_data.last, !rsp_valid, "rsp after last")

endmodule

bind sector_elephant_diffuser_unit sed_checker u_sed_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
